FILE: sv/sed_pkg.sv
// Shared types, constants and character tables of the string escape decoder.
// Used by every module of the block; depends on nothing else.
package sed_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_END_BSLASH  = 2'd1;
    localparam logic [1:0] ERR_BAD_ESCAPE  = 2'd2;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X         = 8'h78;
    localparam logic [7:0] ESC_BYTE       = 8'h1B;
    localparam logic [7:0] CLAMP_MAX      = 8'hFF;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [2:0] OCT_MAX_DIGITS = 3'd4;
    localparam logic [4:0] HEX_LETTER_BASE = 5'd10;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [1:0]  error_code;
        logic        is_last;
        logic [15:0] byte_count;
    } result_t;

    typedef struct packed {
        logic    has_second;
        result_t first;
        result_t second;
    } entry_t;

    // Replacement byte of a single-character escape, zero when there is none.
    function automatic logic [7:0] simple_escape(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h22:   r = 8'h22;
            8'h27:   r = 8'h27;
            8'h5C:   r = 8'h5C;
            8'h61:   r = 8'h07;
            8'h62:   r = 8'h08;
            8'h45:   r = ESC_BYTE;
            8'h65:   r = ESC_BYTE;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            8'h76:   r = 8'h0B;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Valid flag in the top bit, digit value in the low four bits.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        logic [4:0] sum;
        r = 5'd0;
        sum = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            sum = HEX_LETTER_BASE + {2'b00, c[2:0]} - 5'd1;
            r = {1'b1, sum[3:0]};
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == COUNT_MAX) ? v : v + 16'd1;
    endfunction

endpackage

FILE: sv/sed_front.sv
// Front end: accepts characters, tracks the escape state and classifies each
// character into zero, one or two finished results. Depends on sed_pkg.
module sed_front import sed_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       end_of_string,
    input  logic       push_full,
    output logic       push_valid,
    output entry_t     push_entry
);

    localparam logic [2:0] MODE_PLAIN    = 3'd0;
    localparam logic [2:0] MODE_ESC      = 3'd1;
    localparam logic [2:0] MODE_OCT      = 3'd2;
    localparam logic [2:0] MODE_HEXSTART = 3'd3;
    localparam logic [2:0] MODE_HEX      = 3'd4;
    localparam logic [2:0] MODE_DROP     = 3'd5;

    logic [2:0]  mode_reg, mode_next;
    logic [11:0] value_reg, value_next;
    logic [2:0]  taken_reg, taken_next;
    logic [15:0] count_reg, count_next;

    logic        accept;
    logic [7:0]  esc_byte;
    logic        is_oct;
    logic [4:0]  hex;
    logic [11:0] oct_acc;
    logic [11:0] hex_acc;
    logic [2:0]  taken_inc;
    logic        plain;
    logic [1:0]  n;
    logic [7:0]  b0, b1;
    logic [1:0]  e0, e1;
    logic        l0, l1;
    logic [15:0] cnt0, cnt1;

    function automatic logic [7:0] clamp(input logic [11:0] v);
        return (v > {4'd0, CLAMP_MAX}) ? CLAMP_MAX : v[7:0];
    endfunction

    assign in_ready = !push_full;
    assign accept   = in_valid && in_ready;
    assign esc_byte = simple_escape(in_char);
    assign is_oct   = (in_char[7:3] == 5'b00110);
    assign hex      = hex_digit(in_char);
    assign oct_acc  = {value_reg[8:0], in_char[2:0]};
    assign hex_acc  = {value_reg[7:0], hex[3:0]};
    assign taken_inc = taken_reg + 3'd1;

    always_comb begin
        mode_next  = mode_reg;
        value_next = value_reg;
        taken_next = taken_reg;
        plain = 1'b0;
        n  = 2'd0;
        b0 = 8'd0;
        e0 = ERR_NONE;
        l0 = 1'b0;
        b1 = 8'd0;
        e1 = ERR_NONE;
        l1 = 1'b0;
        unique case (mode_reg)
            MODE_DROP: begin
            end
            MODE_ESC: begin
                if (esc_byte != 8'd0) begin
                    n = 2'd1;
                    b0 = esc_byte;
                    l0 = end_of_string;
                    mode_next = MODE_PLAIN;
                end else if (is_oct) begin
                    value_next = {9'd0, in_char[2:0]};
                    taken_next = 3'd1;
                    mode_next  = MODE_OCT;
                    if (end_of_string) begin
                        n = 2'd1;
                        b0 = {5'd0, in_char[2:0]};
                        l0 = 1'b1;
                    end
                end else if (in_char == CHAR_X && !end_of_string) begin
                    mode_next = MODE_HEXSTART;
                end else begin
                    n = 2'd1;
                    e0 = ERR_BAD_ESCAPE;
                    l0 = 1'b1;
                    mode_next = MODE_DROP;
                end
            end
            MODE_OCT: begin
                if (is_oct) begin
                    value_next = oct_acc;
                    taken_next = taken_inc;
                    if (taken_inc >= OCT_MAX_DIGITS || end_of_string) begin
                        n = 2'd1;
                        b0 = clamp(oct_acc);
                        l0 = end_of_string;
                        mode_next = MODE_PLAIN;
                    end
                end else begin
                    n = 2'd1;
                    b0 = clamp(value_reg);
                    plain = 1'b1;
                end
            end
            MODE_HEXSTART: begin
                if (hex[4]) begin
                    value_next = {8'd0, hex[3:0]};
                    taken_next = 3'd1;
                    mode_next  = MODE_HEX;
                    if (end_of_string) begin
                        n = 2'd1;
                        b0 = {4'd0, hex[3:0]};
                        l0 = 1'b1;
                    end
                end else begin
                    n = 2'd1;
                    e0 = ERR_BAD_ESCAPE;
                    l0 = 1'b1;
                    mode_next = MODE_DROP;
                end
            end
            MODE_HEX: begin
                if (hex[4]) begin
                    value_next = hex_acc;
                    taken_next = taken_inc;
                    n = 2'd1;
                    b0 = hex_acc[7:0];
                    l0 = end_of_string;
                    mode_next = MODE_PLAIN;
                end else begin
                    n = 2'd1;
                    b0 = value_reg[7:0];
                    plain = 1'b1;
                end
            end
            default: begin
                plain = 1'b1;
            end
        endcase

        if (plain) begin
            mode_next = MODE_PLAIN;
            if (in_char == CHAR_BACKSLASH && !end_of_string) begin
                mode_next = MODE_ESC;
            end else if (n == 2'd0) begin
                n = 2'd1;
                b0 = (in_char == CHAR_BACKSLASH) ? 8'd0 : in_char;
                e0 = (in_char == CHAR_BACKSLASH) ? ERR_END_BSLASH : ERR_NONE;
                l0 = end_of_string;
            end else begin
                n = 2'd2;
                b1 = (in_char == CHAR_BACKSLASH) ? 8'd0 : in_char;
                e1 = (in_char == CHAR_BACKSLASH) ? ERR_END_BSLASH : ERR_NONE;
                l1 = end_of_string;
            end
        end

        if (end_of_string) begin
            mode_next  = MODE_PLAIN;
            value_next = 12'd0;
            taken_next = 3'd0;
        end
    end

    assign cnt0 = (e0 == ERR_NONE) ? sat_inc(count_reg) : count_reg;
    assign cnt1 = (e1 == ERR_NONE) ? sat_inc(cnt0) : cnt0;

    always_comb begin
        if (end_of_string) begin
            count_next = 16'd0;
        end else if (n == 2'd2) begin
            count_next = cnt1;
        end else if (n == 2'd1) begin
            count_next = cnt0;
        end else begin
            count_next = count_reg;
        end
    end

    assign push_valid = accept && (n != 2'd0);
    assign push_entry = '{has_second: (n == 2'd2),
                          first:  '{out_byte: b0, error_code: e0, is_last: l0, byte_count: cnt0},
                          second: '{out_byte: b1, error_code: e1, is_last: l1, byte_count: cnt1}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_PLAIN;
            value_reg <= 12'd0;
            taken_reg <= 3'd0;
            count_reg <= 16'd0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            value_reg <= value_next;
            taken_reg <= taken_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: sv/sed_queue.sv
// Short register queue of classified entries between the front and back ends.
// Depends on sed_pkg for the entry type.
module sed_queue import sed_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   wr_valid,
    input  entry_t wr_entry,
    output logic   full,
    output logic   rd_valid,
    input  logic   rd_ready,
    output entry_t rd_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t            slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              do_wr, do_rd;

    assign full     = (fill_reg == CNT_FULL);
    assign rd_valid = (fill_reg != '0);
    assign rd_entry = slots_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        fill_next = fill_reg;
        if (do_wr && !do_rd) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (do_rd && !do_wr) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

FILE: sv/sed_back.sv
// Back end: unpacks queue entries into single results and holds the output
// register of the result channel. Depends on sed_pkg.
module sed_back import sed_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_ready,
    input  entry_t  q_entry,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    out_valid_reg;
    result_t out_result_reg;
    logic    pend_reg;
    result_t pend_result_reg;
    logic    load;

    assign load     = !out_valid_reg || out_ready;
    assign q_ready  = load && !pend_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            if (pend_reg) begin
                out_result_reg <= pend_result_reg;
            end else if (q_valid) begin
                out_result_reg  <= q_entry.first;
                pend_result_reg <= q_entry.second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else if (load) begin
            if (pend_reg) begin
                out_valid_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end else begin
                out_valid_reg <= q_valid;
                pend_reg      <= q_valid && q_entry.has_second;
            end
        end
    end

endmodule

FILE: sv/string_escape_decoder_unit.sv
// Top level of the string escape decoder: front end, entry queue, back end.
// Depends on sed_pkg, sed_front, sed_queue and sed_back.
//
// Usage: characters of a string enter on the s_ channel, one per transfer,
// with s_end_of_string set on the final character. Decoded bytes leave on the
// m_ channel, one per transfer, each with its error code, last flag and the
// running byte count of the string. An error result is always marked last,
// and the rest of that string is dropped without results.
// A result passes through the queue and the output register after the
// transfer of the character that completes it. One character per cycle is
// taken while the queue is not full; the output register gives one result per
// cycle, and the QUEUE_DEPTH-entry queue absorbs the extra result of a
// character that completes two (a pending escape value and a plain character).
// Reset (aresetn low at a clock edge) returns the decoder to plain text,
// clears the byte count and empties the queue and output register.
// When the receiver stalls, the output holds its result, the queue fills,
// and s_ready falls once the queue is full.
module string_escape_decoder_unit import sed_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_char,
    input  logic        s_end_of_string,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_error_code,
    output logic        m_is_last,
    output logic [15:0] m_byte_count
);

    logic    push_valid;
    logic    push_full;
    entry_t  push_entry;
    logic    q_valid;
    logic    q_ready;
    entry_t  q_entry;
    result_t result;

    sed_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_char       (s_in_char),
        .end_of_string (s_end_of_string),
        .push_full     (push_full),
        .push_valid    (push_valid),
        .push_entry    (push_entry)
    );

    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_entry (push_entry),
        .full     (push_full),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_entry (q_entry)
    );

    sed_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_entry    (q_entry),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (result)
    );

    assign m_out_byte   = result.out_byte;
    assign m_error_code = result.error_code;
    assign m_is_last    = result.is_last;
    assign m_byte_count = result.byte_count;

endmodule

FILE: sv/sed_checker.sv
// Port-level checks of the string escape decoder and their bind to the top.
// Depends on sed_pkg and string_escape_decoder_unit.
module sed_checker import sed_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic [1:0]  m_error_code,
    input logic        m_is_last,
    input logic [15:0] m_byte_count
);

    // The output register is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result transfer keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_error_code)
            && $stable(m_is_last) && $stable(m_byte_count))
        else $error("result changed while stalled");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_NONE |-> m_is_last && m_out_byte == 8'd0)
        else $error("error result not marked last or byte not zero");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_error_code == ERR_NONE || m_error_code == ERR_END_BSLASH
            || m_error_code == ERR_BAD_ESCAPE)
        else $error("undefined error code");

    // A good byte always counts itself.
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code == ERR_NONE |-> m_byte_count != 16'd0)
        else $error("byte result with zero count");

endmodule

bind string_escape_decoder_unit sed_checker u_sed_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_byte   (m_out_byte),
    .m_error_code (m_error_code),
    .m_is_last    (m_is_last),
    .m_byte_count (m_byte_count)
);

FILE: tb/sv/string_escape_decoder_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for string_escape_decoder_unit: directed and random strings,
// decoded bytes predicted in the testbench and compared at every result transfer.
// Depends on sed_pkg and the string_escape_decoder_unit RTL.
module string_escape_decoder_unit_test;
    import sed_pkg::*;

    typedef enum logic [2:0] {
        MODE_PLAIN, MODE_ESC, MODE_OCT, MODE_HEX_START, MODE_HEX, MODE_DROP
    } decode_mode_t;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
        bit         drain;
        bit         calm;
    } source_char_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_char = 8'h00;
    logic        s_end_of_string = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic [1:0]  m_error_code;
    logic        m_is_last;
    logic [15:0] m_byte_count;

    source_char_t pending_chars[$];
    result_t      awaited_bytes[$];
    result_t      oldest;

    decode_mode_t decode_mode = MODE_PLAIN;
    logic [11:0]  digit_acc = '0;
    logic [2:0]   digit_count = '0;
    logic [15:0]  string_bytes = '0;

    bit drain_next = 1'b0;
    bit calm_mode = 1'b0;
    bit bursts_on = 1'b1;
    bit char_taken = 1'b0;
    bit long_hold_done = 1'b0;
    int send_gap = 0;
    int hold_left = 0;
    int sent_count = 0;
    int results_seen = 0;
    int random_items = 0;
    int next_drain = 200;
    int failures = 0;

    string_escape_decoder_unit i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_char       (s_in_char),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_error_code    (m_error_code),
        .m_is_last       (m_is_last),
        .m_byte_count    (m_byte_count)
    );

    function automatic logic [7:0] simple_code(input logic [7:0] c);
        case (c)
            "\"", "'", CHAR_BACKSLASH: return c;
            "a": return 8'h07;
            "b": return 8'h08;
            "e", "E": return ESC_BYTE;
            "f": return 8'h0C;
            "n": return 8'h0A;
            "r": return 8'h0D;
            "t": return 8'h09;
            "v": return 8'h0B;
            default: return 8'h00;
        endcase
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [7:0] octal_byte();
        return (digit_acc > 12'd255) ? CLAMP_MAX : digit_acc[7:0];
    endfunction

    task automatic emit_byte(input logic [7:0] b, input logic last);
        if (string_bytes != COUNT_MAX) string_bytes++;
        awaited_bytes.push_back('{out_byte: b, error_code: ERR_NONE, is_last: last,
                                  byte_count: string_bytes});
    endtask

    task automatic emit_error(input logic [1:0] code);
        awaited_bytes.push_back('{out_byte: 8'h00, error_code: code, is_last: 1'b1,
                                  byte_count: string_bytes});
        decode_mode = MODE_DROP;
    endtask

    task automatic decode_char(input logic [7:0] c, input logic eos);
        logic [7:0] rep;
        int hv;
        bit as_plain;
        as_plain = 1'b0;
        rep = simple_code(c);
        hv = hex_value(c);
        case (decode_mode)
            MODE_DROP: ;
            MODE_ESC: begin
                if (rep != 8'h00) begin
                    emit_byte(rep, eos);
                    decode_mode = MODE_PLAIN;
                end else if (c >= "0" && c <= "7") begin
                    digit_acc = 12'(c - "0");
                    digit_count = 3'd1;
                    decode_mode = MODE_OCT;
                    if (eos) emit_byte(octal_byte(), 1'b1);
                end else if (c == CHAR_X && !eos) begin
                    decode_mode = MODE_HEX_START;
                end else begin
                    emit_error(ERR_BAD_ESCAPE);
                end
            end
            MODE_OCT: begin
                if (c >= "0" && c <= "7") begin
                    digit_acc = (digit_acc << 3) + 12'(c - "0");
                    digit_count++;
                    if (digit_count >= OCT_MAX_DIGITS || eos) begin
                        emit_byte(octal_byte(), eos);
                        decode_mode = MODE_PLAIN;
                    end
                end else begin
                    emit_byte(octal_byte(), 1'b0);
                    as_plain = 1'b1;
                end
            end
            MODE_HEX_START: begin
                if (hv >= 0) begin
                    digit_acc = 12'(hv);
                    digit_count = 3'd1;
                    decode_mode = MODE_HEX;
                    if (eos) emit_byte(digit_acc[7:0], 1'b1);
                end else begin
                    emit_error(ERR_BAD_ESCAPE);
                end
            end
            MODE_HEX: begin
                if (hv >= 0) begin
                    digit_acc = (digit_acc << 4) + 12'(hv);
                    digit_count++;
                    emit_byte(digit_acc[7:0], eos);
                    decode_mode = MODE_PLAIN;
                end else begin
                    emit_byte(digit_acc[7:0], 1'b0);
                    as_plain = 1'b1;
                end
            end
            default: as_plain = 1'b1;
        endcase
        if (as_plain) begin
            decode_mode = MODE_PLAIN;
            if (c == CHAR_BACKSLASH) begin
                if (eos) emit_error(ERR_END_BSLASH);
                else decode_mode = MODE_ESC;
            end else begin
                emit_byte(c, eos);
            end
        end
        if (eos) begin
            decode_mode = MODE_PLAIN;
            digit_acc = '0;
            digit_count = '0;
            string_bytes = '0;
        end
    endtask

    function automatic logic [7:0] random_plain();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CHAR_BACKSLASH);
        return c;
    endfunction

    task automatic push_char(input logic [7:0] c, input logic eos);
        pending_chars.push_back('{ch: c, eos: eos, drain: drain_next, calm: calm_mode});
        drain_next = 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
    endtask

    // Error tokens come only at the end of a string, so few characters are lost to dropping.
    task automatic add_random_string();
        logic [7:0] text[$];
        string letters = "\"'\\abeEfnrtv";
        int tokens;
        int kind;
        int v;
        tokens = $urandom_range(1, 8);
        for (int t = 0; t < tokens; t++) begin
            kind = (t == tokens - 1) ? $urandom_range(0, 15) : $urandom_range(0, 12);
            case (kind)
                0, 1, 2, 3, 4: text.push_back(random_plain());
                5, 6: begin
                    text.push_back(CHAR_BACKSLASH);
                    text.push_back(letters[$urandom_range(0, letters.len() - 1)]);
                end
                7, 8: begin
                    text.push_back(CHAR_BACKSLASH);
                    repeat ($urandom_range(1, 4)) text.push_back(8'("0" + $urandom_range(0, 7)));
                end
                9, 10: begin
                    text.push_back(CHAR_BACKSLASH);
                    text.push_back(CHAR_X);
                    repeat ($urandom_range(1, 2)) begin
                        v = $urandom_range(0, 15);
                        if (v < 10) text.push_back(8'("0" + v));
                        else text.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + v - 10));
                    end
                end
                11, 12: text.push_back(8'($urandom_range(1, 255)));
                13: begin
                    do v = $urandom_range(1, 255);
                    while (simple_code(8'(v)) != 8'h00 || (v >= "0" && v <= "7") || v == CHAR_X);
                    text.push_back(CHAR_BACKSLASH);
                    text.push_back(8'(v));
                end
                14: begin
                    do v = $urandom_range(1, 255); while (hex_value(8'(v)) >= 0);
                    text.push_back(CHAR_BACKSLASH);
                    text.push_back(CHAR_X);
                    text.push_back(8'(v));
                end
                default: text.push_back(CHAR_BACKSLASH);
            endcase
        end
        foreach (text[i]) push_char(text[i], i == text.size() - 1);
        random_items += text.size();
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || char_taken) begin
            if (send_gap != 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_chars.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending_chars[0].drain && awaited_bytes.size() != 0) begin
                s_valid <= 1'b0;
            end else if (bursts_on && (sent_count / 96) % 3 != 2 && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 18);
                s_valid <= 1'b0;
            end else begin
                s_valid <= 1'b1;
                s_in_char <= pending_chars[0].ch;
                s_end_of_string <= pending_chars[0].eos;
                bursts_on <= !pending_chars[0].calm;
                void'(pending_chars.pop_front());
                sent_count++;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 150) begin
            long_hold_done = 1'b1;
            hold_left = 299;
            m_ready <= 1'b0;
        end else if (bursts_on && (results_seen / 80) % 3 != 1 && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        char_taken = 1'b0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (awaited_bytes.size() == 0) begin
                    $error("result transfer with none expected: byte %0d, error %0d",
                           m_out_byte, m_error_code);
                    failures++;
                end else begin
                    oldest = awaited_bytes.pop_front();
                    if (oldest.error_code == ERR_NONE && m_out_byte != oldest.out_byte) begin
                        $error("out_byte: expected %0d, actual %0d", oldest.out_byte, m_out_byte);
                        failures++;
                    end
                    if (m_error_code != oldest.error_code) begin
                        $error("error_code: expected %0d, actual %0d",
                               oldest.error_code, m_error_code);
                        failures++;
                    end
                    if (m_is_last != oldest.is_last) begin
                        $error("is_last: expected %0d, actual %0d", oldest.is_last, m_is_last);
                        failures++;
                    end
                    if (m_byte_count != oldest.byte_count) begin
                        $error("byte_count: expected %0d, actual %0d",
                               oldest.byte_count, m_byte_count);
                        failures++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                char_taken = 1'b1;
                decode_char(s_in_char, s_end_of_string);
            end
        end
    end

    initial begin
        push_char(8'h01, 1'b1);
        push_char(8'hFF, 1'b1);
        send_text("\\777z");
        send_text("\\0012q");
        send_text("\\xAf");
        send_text("\\x5\\");
        send_text("\\xgab");
        send_text("\\x");
        send_text("\\");
        send_text("\\q");
        send_text("\\7");

        drain_next = 1'b1;
        while (random_items < 560) begin
            if (random_items >= next_drain) begin
                drain_next = 1'b1;
                next_drain += 200;
            end
            add_random_string();
        end

        // The closing stretch runs without idling on either side.
        drain_next = 1'b1;
        calm_mode = 1'b1;
        repeat (60) push_char(random_plain(), 1'b0);
        push_char(CHAR_BACKSLASH, 1'b1);
        send_text("ok");

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (pending_chars.size() != 0 || s_valid || awaited_bytes.size() != 0);
        repeat (8) @(posedge aclk);

        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
